@@ rtl/core/mcf_pkg.sv @@
// Shared widths and default sizes for the multichannel FIR filter core.
`timescale 1ns / 1ps
`default_nettype none

package mcf_pkg;

	localparam int CHAN_W       = 5;
	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int PROD_W       = SAMPLE_W + COEF_W;
	localparam int SUM_W        = 35;
	localparam int NUM_REGS     = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int WINDOW_DEF   = 8;
	localparam int CHANNELS_DEF = 18;

endpackage

`default_nettype wire

@@ rtl/core/mcf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mcf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 144
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/multichannel_fir_filter_core.sv @@
// Multichannel FIR filter: per-channel delay lines in RAM, one shared multiply-accumulate.
//
// Input channel (in_valid/in_ready): one sample per transfer with its channel number.
// The sample is written into that channel's delay line at the shared write position,
// then the taps are read back one per cycle from the history RAM and fed through a
// single 16x16 multiplier into a 35-bit accumulator. The write position advances
// after the sample of the highest channel. A channel number out of range gives a
// result of zero and leaves the delay lines and the write position untouched.
// One item is in flight at a time, as the single RAM read port and the shared
// multiplier serve one window: in_ready is high only while the core is idle.
// Output channel (out_valid/out_ready): a result register holds the sum while the
// receiver stalls; the next item is taken meanwhile and waits for that register
// before its result is loaded.
// Configuration (cfg_valid/cfg_ready): coefficient writes, always ready; index i sets
// tap i. Writes to taps at or above WINDOW are ignored.
// Reset clears the coefficients and the write position, then a clearing pass zeroes
// all CHANNELS * WINDOW entries of the history RAM (144 by default), with in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_fir_filter_core #(
	parameter int WINDOW   = mcf_pkg::WINDOW_DEF,
	parameter int CHANNELS = mcf_pkg::CHANNELS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic        [mcf_pkg::CHAN_W-1:0]    chan_in,
	input  wire logic signed [mcf_pkg::SAMPLE_W-1:0]  sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic             [mcf_pkg::CHAN_W-1:0]    chan_out,
	output logic signed      [mcf_pkg::SUM_W-1:0]     filtered,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [mcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [mcf_pkg::COEF_W-1:0]    cfg_data
);

	localparam int DEPTH  = CHANNELS * WINDOW;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int TAP_W  = $clog2(WINDOW + 1);
	localparam int CSEL_W = mcf_pkg::CFG_IDX_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] clr_q;
	logic [POS_W-1:0]  wp_q;
	logic [POS_W-1:0]  pos_q;
	logic [TAP_W-1:0]  tap_q;
	logic [ADDR_W-1:0] base_q;
	logic [mcf_pkg::CHAN_W-1:0] ch_q;

	logic signed [mcf_pkg::COEF_W-1:0] coef_q [mcf_pkg::NUM_REGS];

	logic                    vld_s1, last_s1, vld_s2, last_s2;
	logic [TAP_W-1:0]        tap_s1;
	logic signed [mcf_pkg::PROD_W-1:0] prod_s2;
	logic signed [mcf_pkg::SUM_W-1:0]  acc_q;

	logic                    out_valid_q;
	logic [mcf_pkg::CHAN_W-1:0] chan_out_q;
	logic signed [mcf_pkg::SUM_W-1:0] filtered_q;

	logic                    accept;
	logic                    ch_ok;
	logic [ADDR_W-1:0]       in_base;
	logic                    issue;
	logic                    load_out;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [mcf_pkg::SAMPLE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [mcf_pkg::SAMPLE_W-1:0] ram_rdata;
	logic signed [mcf_pkg::COEF_W-1:0] coef_sel;
	logic [CSEL_W-1:0]       csel;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign ch_ok     = (32'(chan_in) < CHANNELS);
	assign in_base   = ADDR_W'(32'(chan_in) * WINDOW);
	assign issue     = (state_q == ST_RUN) && (tap_q != TAP_W'(WINDOW));
	assign load_out  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = accept && ch_ok;
			ram_waddr = in_base + ADDR_W'(wp_q);
			ram_wdata = sample;
		end
	end

	assign ram_raddr = base_q + ADDR_W'(pos_q);

	mcf_ram #(
		.WIDTH (mcf_pkg::SAMPLE_W),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// taps beyond the configurable registers carry a zero coefficient
	assign csel     = CSEL_W'(tap_s1);
	assign coef_sel = (32'(tap_s1) < mcf_pkg::NUM_REGS) ? coef_q[csel] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcf_pkg::NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid && (32'(cfg_index) < WINDOW)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			pos_q       <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (ch_ok) begin
							pos_q   <= wp_q;
							tap_q   <= '0;
							state_q <= ST_RUN;
							if (32'(chan_in) == CHANNELS - 1) begin
								wp_q <= (wp_q == POS_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
							end
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RUN: begin
					if (issue) begin
						tap_q <= tap_q + 1'b1;
						pos_q <= (pos_q == '0) ? POS_W'(WINDOW - 1) : pos_q - 1'b1;
					end
					if (vld_s2 && last_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold the sum until the result register frees up
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= issue && (tap_q == TAP_W'(WINDOW - 1));
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1  <= tap_q;
		prod_s2 <= $signed(ram_rdata) * coef_sel;
		if (accept) begin
			ch_q   <= chan_in;
			base_q <= in_base;
			acc_q  <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + mcf_pkg::SUM_W'(prod_s2);
		end
		if (load_out) begin
			chan_out_q <= ch_q;
			filtered_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign chan_out  = chan_out_q;
	assign filtered  = filtered_q;

endmodule

`default_nettype wire

@@ verif/tb_multichannel_fir_filter_core.sv @@
// Testbench for the multichannel FIR filter core: directed table, then random frames.
`timescale 1ns / 1ps

module tb_multichannel_fir_filter_core;

	localparam int TAPS        = mcf_pkg::WINDOW_DEF;
	localparam int CHANS       = mcf_pkg::CHANNELS_DEF;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 143;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic {ROW_SAMPLE, ROW_COEF} row_kind_t;

	typedef enum int {MODE_MAX, MODE_MIN, MODE_ALTERNATE, MODE_RANDOM, MODE_MIXED} coef_mode_t;

	typedef struct packed {
		logic [mcf_pkg::CHAN_W-1:0]       chan;
		logic signed [mcf_pkg::SUM_W-1:0] filtered;
	} fir_result_t;

	typedef struct packed {
		row_kind_t                        kind;
		logic [mcf_pkg::CHAN_W-1:0]       chan;
		logic [mcf_pkg::CFG_IDX_W-1:0]    idx;
		logic [15:0]                      data;
		logic                             typed;
		logic signed [mcf_pkg::SUM_W-1:0] result;
	} dir_step_t;

	localparam int DIR_LEN = 24;

	// typed results hold only while the taps they rely on are known at a glance
	dir_step_t dir_steps [DIR_LEN] = '{
		'{ROW_SAMPLE, 5'd0,  3'd0, 16'h7fff, 1'b1, 35'sd0},
		'{ROW_SAMPLE, 5'd17, 3'd0, 16'h8000, 1'b1, 35'sd0},
		'{ROW_SAMPLE, 5'd18, 3'd0, 16'h1234, 1'b1, 35'sd0},
		'{ROW_SAMPLE, 5'd31, 3'd0, 16'hffff, 1'b1, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd0, 16'h8000, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd1,  3'd0, 16'h7fff, 1'b1, -35'sd1073709056},
		'{ROW_SAMPLE, 5'd2,  3'd0, 16'h8000, 1'b1, 35'sd1073741824},
		'{ROW_SAMPLE, 5'd3,  3'd0, 16'h0000, 1'b1, 35'sd0},
		'{ROW_SAMPLE, 5'd20, 3'd0, 16'h7fff, 1'b1, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd1, 16'h7fff, 1'b0, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd2, 16'h8000, 1'b0, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd3, 16'h0001, 1'b0, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd4, 16'hffff, 1'b0, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd5, 16'h4000, 1'b0, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd6, 16'hc000, 1'b0, 35'sd0},
		'{ROW_COEF,   5'd0,  3'd7, 16'h7fff, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd17, 3'd0, 16'h8000, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd0,  3'd0, 16'h7fff, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd9,  3'd0, 16'h8000, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd0,  3'd0, 16'h8000, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd17, 3'd0, 16'hffff, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd0,  3'd0, 16'h7fff, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd16, 3'd0, 16'h5a5a, 1'b0, 35'sd0},
		'{ROW_SAMPLE, 5'd21, 3'd0, 16'ha5a5, 1'b1, 35'sd0}
	};

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic        [mcf_pkg::CHAN_W-1:0]    chan_in;
	logic signed [mcf_pkg::SAMPLE_W-1:0]  sample;
	logic                                 out_valid;
	logic                                 out_ready;
	logic        [mcf_pkg::CHAN_W-1:0]    chan_out;
	logic signed [mcf_pkg::SUM_W-1:0]     filtered;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic        [mcf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic        [mcf_pkg::COEF_W-1:0]    cfg_data;

	// model of the filter state
	logic signed [mcf_pkg::SAMPLE_W-1:0] history [CHANS][TAPS];
	logic signed [mcf_pkg::COEF_W-1:0]   coef_model [TAPS];
	int                                  wr_pos;

	fir_result_t pending_outputs [$];
	fir_result_t oldest;
	int          mismatches;
	int          cycle_count;
	logic        no_idle;

	multichannel_fir_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.chan_in   (chan_in),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.chan_out  (chan_out),
		.filtered  (filtered),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// store the sample, then sum the channel's window against the taps
	function automatic fir_result_t filter_sample(input logic [mcf_pkg::CHAN_W-1:0] ch,
			input logic signed [mcf_pkg::SAMPLE_W-1:0] smp);
		fir_result_t r;
		longint      acc;
		int          pos;
		int          j;
		r.chan     = ch;
		r.filtered = '0;
		if (ch < CHANS) begin
			history[ch][wr_pos] = smp;
			acc = 0;
			for (j = 0; j < TAPS; j++) begin
				pos = (wr_pos + TAPS - j) % TAPS;
				acc += longint'(history[ch][pos]) * longint'(coef_model[j]);
			end
			if (ch == CHANS - 1)
				wr_pos = (wr_pos + 1) % TAPS;
			r.filtered = acc[mcf_pkg::SUM_W-1:0];
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic logic [15:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_coef(input coef_mode_t mode, input int k);
		case (mode)
			MODE_MAX: return 16'h7fff;
			MODE_MIN: return 16'h8000;
			MODE_ALTERNATE: return k[0] ? 16'h8000 : 16'h7fff;
			MODE_RANDOM: return 16'($urandom);
			default: begin
				if ($urandom_range(0, 3) == 0)
					return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic send_sample(input logic [mcf_pkg::CHAN_W-1:0] ch, input logic [15:0] smp,
			input logic typed, input logic signed [mcf_pkg::SUM_W-1:0] typed_result);
		int          gap;
		fir_result_t r;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		r = filter_sample(ch, smp);
		if (typed)
			r.filtered = typed_result;
		pending_outputs.push_back(r);
		in_valid <= 1'b1;
		chan_in  <= ch;
		sample   <= smp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_coef(input logic [mcf_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx < TAPS)
			coef_model[idx] = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected result chan_out %0d filtered %0d", $time, chan_out,
					filtered);
				mismatches++;
			end else begin
				oldest = pending_outputs.pop_front();
				if (chan_out !== oldest.chan) begin
					$display("%0t: chan_out expected %0d got %0d", $time, oldest.chan, chan_out);
					mismatches++;
				end
				if (filtered !== oldest.filtered) begin
					$display("%0t: filtered expected %0d got %0d (chan %0d)", $time,
						oldest.filtered, filtered, oldest.chan);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int                         p;
		int                         k;
		int                         n;
		int                         c;
		int                         t;
		logic [mcf_pkg::CHAN_W-1:0] next_ch;
		logic [mcf_pkg::CHAN_W-1:0] ch;
		coef_mode_t                 mode;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		chan_in     = '0;
		sample      = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		no_idle     = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		wr_pos      = 0;
		for (c = 0; c < CHANS; c++)
			for (t = 0; t < TAPS; t++)
				history[c][t] = '0;
		for (t = 0; t < TAPS; t++)
			coef_model[t] = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_steps[i]) begin
			if (dir_steps[i].kind == ROW_COEF) begin
				settle();
				write_coef(dir_steps[i].idx, dir_steps[i].data);
			end else begin
				send_sample(dir_steps[i].chan, dir_steps[i].data, dir_steps[i].typed,
					dir_steps[i].result);
			end
		end

		// mostly in-order frames, with stray and out-of-range channels mixed in
		for (p = 0; p < PHASES; p++) begin
			settle();
			mode = (p < 3) ? coef_mode_t'(p) : coef_mode_t'($urandom_range(MODE_RANDOM, MODE_MIXED));
			for (k = 0; k < TAPS; k++)
				write_coef(k[mcf_pkg::CFG_IDX_W-1:0], pick_coef(mode, k));
			no_idle = (p % 3 == 1);
			next_ch = '0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 88) begin
					ch      = next_ch;
					next_ch = (next_ch == CHANS - 1) ? '0 : next_ch + 1'b1;
				end else begin
					ch = mcf_pkg::CHAN_W'($urandom_range(0, 31));
				end
				send_sample(ch, random_sample(), 1'b0, '0);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
